// ===== src/rle_block_decoder_top_macros.svh =====
// Assertion macros shared by the run-length block decoder modules.
// Needs i_clk and i_rst_n in scope at the point of use.
`ifndef RLE_BLOCK_DECODER_TOP_MACROS_SVH
`define RLE_BLOCK_DECODER_TOP_MACROS_SVH

// Same-cycle implication, off while reset is held
`define RBD_ASSERT_IMP(lbl, a, c, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (c)) \
        else $error(msg);

// Next-cycle implication, off while reset is held
`define RBD_ASSERT_NXT(lbl, a, c, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (c)) \
        else $error(msg);

`endif

// ===== src/rbd_pkg.sv =====
// Package for the run-length block decoder: item types, codes, constants.
// No dependencies.
package rbd_pkg;

    localparam int LENGTH_BITS = 24;
    localparam int WORD_BYTES  = 8;
    localparam int RUN_BIAS    = 128;
    localparam int RUN_MIN     = 3;

    typedef enum logic [1:0] {
        K_START = 2'd0,
        K_DATA  = 2'd1,
        K_END   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_TRUNC    = 2'd2,
        ST_SHORT    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        PH_CTRL = 2'd0,
        PH_RUN  = 2'd1,
        PH_LIT  = 2'd2
    } t_phase;

    typedef struct packed {
        logic [1:0]             kind;
        logic [7:0]             data_byte;
        logic [LENGTH_BITS-1:0] expected_length;
    } t_in_item;

    typedef struct packed {
        logic [8*WORD_BYTES-1:0] word_data;
        logic [3:0]              byte_count;
        logic                    is_status;
        logic [1:0]              status;
        logic                    last_of_item;
    } t_out_item;

    // Work handed from the stream control to the output expander
    typedef struct packed {
        logic       valid;
        logic [7:0] data_byte;
        logic [7:0] len;
        logic       is_status;
        logic [1:0] status;
    } t_load;

endpackage

// ===== src/rbd_ctrl.sv =====
// Stream control of the run-length block decoder: phase, counters, status.
// Depends on rbd_pkg.
module rbd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  rbd_pkg::t_in_item i_item,
    output rbd_pkg::t_load    o_load
);
    import rbd_pkg::*;

    t_phase                 r_phase,    n_phase;
    logic [7:0]             r_lit_left, n_lit_left;
    logic [7:0]             r_run_len,  n_run_len;
    logic [LENGTH_BITS-1:0] r_produced, n_produced;
    logic [LENGTH_BITS-1:0] r_target,   n_target;
    logic                   r_error,    n_error;

    logic [7:0]           w_len;
    logic                 w_is_run;
    logic [LENGTH_BITS:0] w_room;
    logic                 w_over;
    t_status              w_end_status;

    // Control byte decode and room check; a borrow means room is huge
    assign w_is_run = i_item.data_byte[7];
    assign w_len    = w_is_run ? (i_item.data_byte - 8'(RUN_BIAS) + 8'(RUN_MIN))
                               : (i_item.data_byte + 8'd1);
    assign w_room   = {1'b0, r_target} - {1'b0, r_produced};
    assign w_over   = !w_room[LENGTH_BITS] &&
                      ({{(LENGTH_BITS-7){1'b0}}, w_len} > w_room);

    // End-of-stream status
    always_comb begin
        if (r_error) begin
            w_end_status = ST_OVERFLOW;
        end else if (r_phase == PH_RUN || r_phase == PH_LIT) begin
            w_end_status = ST_TRUNC;
        end else if (r_produced != r_target) begin
            w_end_status = ST_SHORT;
        end else begin
            w_end_status = ST_OK;
        end
    end

    // Next state
    always_comb begin
        n_phase    = r_phase;
        n_lit_left = r_lit_left;
        n_run_len  = r_run_len;
        n_produced = r_produced;
        n_target   = r_target;
        n_error    = r_error;
        if (i_accept) begin
            case (i_item.kind)
                K_START, K_END: begin
                    n_phase    = PH_CTRL;
                    n_lit_left = '0;
                    n_run_len  = '0;
                    n_produced = '0;
                    n_error    = 1'b0;
                    n_target   = (i_item.kind == K_START) ? i_item.expected_length : '0;
                end
                K_DATA: begin
                    if (!r_error) begin
                        case (r_phase)
                            PH_RUN: begin
                                n_produced = r_produced
                                           + {{(LENGTH_BITS-8){1'b0}}, r_run_len};
                                n_run_len  = '0;
                                n_phase    = PH_CTRL;
                            end
                            PH_LIT: begin
                                n_produced = r_produced
                                           + {{(LENGTH_BITS-1){1'b0}}, 1'b1};
                                n_lit_left = r_lit_left - 8'd1;
                                if (r_lit_left == 8'd1) begin
                                    n_phase = PH_CTRL;
                                end
                            end
                            default: begin
                                if (w_over) begin
                                    n_error = 1'b1;
                                end else if (w_is_run) begin
                                    n_run_len = w_len;
                                    n_phase   = PH_RUN;
                                end else begin
                                    n_lit_left = w_len;
                                    n_phase    = PH_LIT;
                                end
                            end
                        endcase
                    end
                end
                default: ;
            endcase
        end
    end

    // Work for the output expander
    always_comb begin
        o_load           = '0;
        o_load.data_byte = i_item.data_byte;
        if (i_accept) begin
            case (i_item.kind)
                K_END: begin
                    o_load.valid     = 1'b1;
                    o_load.is_status = 1'b1;
                    o_load.status    = w_end_status;
                end
                K_DATA: begin
                    if (!r_error && r_phase == PH_RUN) begin
                        o_load.valid = 1'b1;
                        o_load.len   = r_run_len;
                    end else if (!r_error && r_phase == PH_LIT) begin
                        o_load.valid = 1'b1;
                        o_load.len   = 8'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_CTRL;
            r_lit_left <= '0;
            r_run_len  <= '0;
            r_produced <= '0;
            r_target   <= '0;
            r_error    <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_lit_left <= n_lit_left;
            r_run_len  <= n_run_len;
            r_produced <= n_produced;
            r_target   <= n_target;
            r_error    <= n_error;
        end
    end

`include "rle_block_decoder_top_macros.svh"

    `RBD_ASSERT_IMP(a_run_has_len, r_phase == PH_RUN, r_run_len >= 8'(RUN_MIN), "run phase with short run")
    `RBD_ASSERT_IMP(a_lit_has_left, r_phase == PH_LIT, r_lit_left != 8'd0, "literal phase with none left")
    `RBD_ASSERT_IMP(a_no_excess, !r_error, r_produced <= r_target, "decoded more than expected")

endmodule

// ===== src/rbd_expand.sv =====
// Output register of the run-length block decoder: splits runs into words.
// Depends on rbd_pkg.
module rbd_expand (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rbd_pkg::t_load     i_load,
    output logic               o_ready,
    output logic               o_valid,
    input  logic               i_stall,
    output rbd_pkg::t_out_item o_item
);
    import rbd_pkg::*;

    logic       r_busy,   n_busy;
    logic [7:0] r_byte,   n_byte;
    logic [7:0] r_left,   n_left;
    logic       r_is_stat, n_is_stat;
    logic [1:0] r_status, n_status;

    logic [3:0] w_chunk;
    logic       w_last;
    logic       w_fire;
    logic       w_finish;

    // Current word: up to a full word of the run byte
    assign w_chunk = r_is_stat ? 4'd0 :
                     (r_left > 8'(WORD_BYTES)) ? 4'(WORD_BYTES) : r_left[3:0];
    assign w_last  = r_is_stat || (r_left <= 8'(WORD_BYTES));
    assign w_fire   = r_busy && !i_stall;
    assign w_finish = w_fire && w_last;
    assign o_ready  = !r_busy || w_finish;
    assign o_valid  = r_busy;

    always_comb begin
        o_item              = '0;
        o_item.byte_count   = w_chunk;
        o_item.is_status    = r_is_stat;
        o_item.status       = r_status;
        o_item.last_of_item = w_last;
        for (int i = 0; i < WORD_BYTES; i++) begin
            if (4'(i) < w_chunk) begin
                o_item.word_data[8*i +: 8] = r_byte;
            end
        end
    end

    // Load new work, step through a run, or drain
    always_comb begin
        n_busy    = r_busy;
        n_byte    = r_byte;
        n_left    = r_left;
        n_is_stat = r_is_stat;
        n_status  = r_status;
        if (i_load.valid) begin
            n_busy    = 1'b1;
            n_byte    = i_load.data_byte;
            n_left    = i_load.len;
            n_is_stat = i_load.is_status;
            n_status  = i_load.status;
        end else if (w_finish) begin
            n_busy = 1'b0;
        end else if (w_fire) begin
            n_left = r_left - {4'd0, w_chunk};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte    <= n_byte;
        r_left    <= n_left;
        r_is_stat <= n_is_stat;
        r_status  <= n_status;
    end

`include "rle_block_decoder_top_macros.svh"

    `RBD_ASSERT_IMP(a_load_when_free, i_load.valid, o_ready, "work loaded over pending results")
    `RBD_ASSERT_IMP(a_data_nonempty, r_busy && !r_is_stat, w_chunk != 4'd0, "data item with no bytes")
    `RBD_ASSERT_NXT(a_run_steps, w_fire && !w_last, r_busy && r_left > 8'd0, "run ended early")
    `RBD_ASSERT_NXT(a_hold_stalled, r_busy && i_stall, r_busy && $stable(r_left), "stalled run moved")

endmodule

// ===== src/rle_block_decoder_top.sv =====
// Results of an item appear in the cycle after it is accepted. One item per cycle
// is taken unless stalled; a run gives ceil(length/8) results, one per unstalled
// cycle from the output register, and the input is held until the last is taken.
// Items that give no result also wait while earlier results are still pending.
// Reset (i_rst_n low, synchronous) clears the stream state and empties the output.
// Top level: rbd_ctrl for stream state, rbd_expand for the output register.
module rle_block_decoder_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  rbd_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output rbd_pkg::t_out_item o_out_item
);
    import rbd_pkg::*;

    t_load w_load;
    logic  w_ready;
    logic  w_accept;

    // Take an item whenever the output register is free or finishing
    assign o_in_stall = !w_ready;
    assign w_accept   = i_in_valid && w_ready;

    rbd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_item   (i_in_item),
        .o_load   (w_load)
    );

    rbd_expand u_expand (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .o_ready (w_ready),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_item  (o_out_item)
    );

endmodule
